// File: design/tcbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcbd_pkg
// Shared types and constants for the triangle coverage / barycentric block.
// ---------------------------------------------------------------------------
package tcbd_pkg;

   localparam int COORD_W          = 16;
   localparam int DIFF_W           = COORD_W + 1;
   localparam int PROD_W           = 2 * DIFF_W;
   localparam int EDGE_W           = PROD_W + 1;
   localparam int ABS_W            = EDGE_W;
   localparam int DEPTH_W          = 16;
   localparam int WEIGHT_W         = 32;
   localparam int WEIGHT_FRAC_BITS = 16;
   localparam int ZPROD_W          = EDGE_W + DEPTH_W + 1;
   localparam int ZSUM_W           = ZPROD_W + 2;
   localparam int DIV_NUM_W        = 54;
   localparam int DIV_DEN_W        = ABS_W;
   localparam int DIV_Q_W          = WEIGHT_W;
   localparam int CSR_ADDR_W       = 5;
   localparam int CSR_DATA_W       = 32;

   localparam logic [2:0] REG_VERTEX_A_XY    = 3'd0;
   localparam logic [2:0] REG_VERTEX_B_XY    = 3'd1;
   localparam logic [2:0] REG_VERTEX_C_XY    = 3'd2;
   localparam logic [2:0] REG_VERTEX_A_DEPTH = 3'd3;
   localparam logic [2:0] REG_VERTEX_B_DEPTH = 3'd4;
   localparam logic [2:0] REG_VERTEX_C_DEPTH = 3'd5;

   typedef struct packed {
      logic signed [COORD_W-1:0] pixel_x;
      logic signed [COORD_W-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic                       inside_res;
      logic                       degenerate;
      logic signed [WEIGHT_W-1:0] weight_a;
      logic signed [WEIGHT_W-1:0] weight_b;
      logic signed [WEIGHT_W-1:0] weight_c;
      logic [DEPTH_W-1:0]         depth;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic covered;
      logic degen;
      logic neg_a;
      logic neg_b;
      logic neg_c;
      logic neg_z;
   } side_type;

endpackage
`default_nettype wire

// File: design/tcbd_edge.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcbd_edge
// Three-stage front end: vertex differences, cross products, edge values
// and doubled signed area.
// ---------------------------------------------------------------------------
module tcbd_edge (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                en,
   input  wire logic                                in_valid,
   input  wire tcbd_pkg::req_type                   in_pix,
   input  wire logic [31:0]                         vtx_a_xy,
   input  wire logic [31:0]                         vtx_b_xy,
   input  wire logic [31:0]                         vtx_c_xy,
   output logic                                     out_valid,
   output logic signed [tcbd_pkg::EDGE_W-1:0]       na,
   output logic signed [tcbd_pkg::EDGE_W-1:0]       nb,
   output logic signed [tcbd_pkg::EDGE_W-1:0]       nc,
   output logic signed [tcbd_pkg::EDGE_W-1:0]       area
);
   import tcbd_pkg::*;

   logic signed [DIFF_W-1:0] ax, ay, bx, by, cx, cy, px, py;
   logic signed [DIFF_W-1:0] d_in [12];
   logic signed [DIFF_W-1:0] d_ff [12];
   logic signed [PROD_W-1:0] p_ff [8];
   logic signed [EDGE_W-1:0] e_ff [4];
   logic [2:0]               vld_ff;

   assign ax = DIFF_W'($signed(vtx_a_xy[15:0]));
   assign ay = DIFF_W'($signed(vtx_a_xy[31:16]));
   assign bx = DIFF_W'($signed(vtx_b_xy[15:0]));
   assign by = DIFF_W'($signed(vtx_b_xy[31:16]));
   assign cx = DIFF_W'($signed(vtx_c_xy[15:0]));
   assign cy = DIFF_W'($signed(vtx_c_xy[31:16]));
   assign px = DIFF_W'(in_pix.pixel_x);
   assign py = DIFF_W'(in_pix.pixel_y);

   always_comb begin
      d_in[0]  = cx - bx;   // c - b
      d_in[1]  = cy - by;
      d_in[2]  = px - bx;   // p - b
      d_in[3]  = py - by;
      d_in[4]  = ax - cx;   // a - c
      d_in[5]  = ay - cy;
      d_in[6]  = px - cx;   // p - c
      d_in[7]  = py - cy;
      d_in[8]  = bx - ax;   // b - a
      d_in[9]  = by - ay;
      d_in[10] = px - ax;   // p - a
      d_in[11] = py - ay;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff     <= d_in;
         p_ff[0]  <= d_ff[0] * d_ff[3];
         p_ff[1]  <= d_ff[1] * d_ff[2];
         p_ff[2]  <= d_ff[4] * d_ff[7];
         p_ff[3]  <= d_ff[5] * d_ff[6];
         p_ff[4]  <= d_ff[8] * d_ff[11];
         p_ff[5]  <= d_ff[9] * d_ff[10];
         // area: (c - b) x (a - b), a - b = -(b - a)
         p_ff[6]  <= -(d_ff[0] * d_ff[9]);
         p_ff[7]  <= -(d_ff[1] * d_ff[8]);
         e_ff[0]  <= EDGE_W'(p_ff[0]) - EDGE_W'(p_ff[1]);
         e_ff[1]  <= EDGE_W'(p_ff[2]) - EDGE_W'(p_ff[3]);
         e_ff[2]  <= EDGE_W'(p_ff[4]) - EDGE_W'(p_ff[5]);
         e_ff[3]  <= EDGE_W'(p_ff[6]) - EDGE_W'(p_ff[7]);
      end
   end

   assign out_valid = vld_ff[2];
   assign na        = e_ff[0];
   assign nb        = e_ff[1];
   assign nc        = e_ff[2];
   assign area      = e_ff[3];

endmodule
`default_nettype wire

// File: design/tcbd_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcbd_divider
// Pipelined restoring divider, one quotient bit per stage, with overflow
// flag for quotients that do not fit Q_W bits.
// ---------------------------------------------------------------------------
module tcbd_divider #(
   parameter int NUM_W = 54,
   parameter int DEN_W = 35,
   parameter int Q_W   = 32
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic      [Q_W-1:0]   quo,
   output logic                  ovf
);
   localparam int DW = (DEN_W + Q_W > NUM_W) ? DEN_W + Q_W : NUM_W;

   logic [NUM_W-1:0] rem_ff [Q_W+1];
   logic [DEN_W-1:0] den_ff [Q_W+1];
   logic [Q_W-1:0]   quo_ff [Q_W+1];
   logic             ovf_ff [Q_W+1];
   logic             ovf_in;

   assign ovf_in = DW'(num) >= (DW'(den) << Q_W);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num;
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         ovf_ff[0] <= ovf_in;
      end
   end

   for (genvar k = 1; k <= Q_W; k++) begin : g_stage
      logic [DW-1:0]    trial;
      logic [DW-1:0]    rext;
      logic             ge;
      logic [NUM_W-1:0] rem_in;
      logic [Q_W-1:0]   quo_in;

      always_comb begin
         trial  = DW'(den_ff[k-1]) << (Q_W - k);
         rext   = DW'(rem_ff[k-1]);
         ge     = rext >= trial;
         rem_in = ge ? NUM_W'(rext - trial) : rem_ff[k-1];
         quo_in = ge ? (quo_ff[k-1] | (Q_W'(1) << (Q_W - k))) : quo_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_ff[k-1];
            quo_ff[k] <= quo_in;
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quo = quo_ff[Q_W];
   assign ovf = ovf_ff[Q_W];

endmodule
`default_nettype wire

// File: design/triangle_coverage_barycentric_depth.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// triangle_coverage_barycentric_depth
// Per-pixel edge test, barycentric weights and interpolated depth.
// ---------------------------------------------------------------------------
// One pixel transfer is taken per clock unless the result side stalls,
// which freezes the whole pipeline; results pass the edge stages, the setup
// stages, the restoring dividers (one quotient bit per stage) and the
// output register. The user must write vertex registers over the APB port
// only while the pipeline is empty; the block itself does not enforce it.
module triangle_coverage_barycentric_depth (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire tcbd_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output tcbd_pkg::rsp_type                         rsp_data,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [tcbd_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [tcbd_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [tcbd_pkg::CSR_DATA_W-1:0]           prdata,
   output logic                                      pready
);
   import tcbd_pkg::*;

   localparam int DIV_LAT = DIV_Q_W + 1;

   logic [31:0]         vtx_a_xy_ff, vtx_b_xy_ff, vtx_c_xy_ff;
   logic [DEPTH_W-1:0]  vtx_a_z_ff, vtx_b_z_ff, vtx_c_z_ff;
   logic                csr_wr;
   logic [2:0]          csr_idx;

   logic                adv;
   logic                e_valid;
   logic signed [EDGE_W-1:0] na, nb, nc, area;

   // stage 4
   side_type                  s4_ff;
   logic [ABS_W-1:0]          abs_a_ff, abs_b_ff, abs_c_ff, abs_d_ff;
   logic signed [ZPROD_W-1:0] zp_a_ff, zp_b_ff, zp_c_ff;
   logic                      neg_d_ff;

   // stage 5
   side_type                  s5_in, s5_ff;
   logic signed [ZSUM_W-1:0]  zsum;
   logic [ZSUM_W-1:0]         zabs;
   logic [DIV_NUM_W-1:0]      num_a_ff, num_b_ff, num_c_ff, num_z_ff;
   logic [DIV_DEN_W-1:0]      den_ff;
   logic [DIV_NUM_W-1:0]      half;

   side_type                  side_ff [DIV_LAT];
   logic [DIV_Q_W-1:0]        q_a, q_b, q_c, q_z;
   logic                      o_a, o_b, o_c, o_z;

   rsp_type                   rsp_in, rsp_ff;
   logic                      rsp_valid_ff;

   // ---- configuration ----
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[4:2];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vtx_a_xy_ff <= '0;
         vtx_b_xy_ff <= '0;
         vtx_c_xy_ff <= '0;
         vtx_a_z_ff  <= '0;
         vtx_b_z_ff  <= '0;
         vtx_c_z_ff  <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_VERTEX_A_XY:    vtx_a_xy_ff <= pwdata;
            REG_VERTEX_B_XY:    vtx_b_xy_ff <= pwdata;
            REG_VERTEX_C_XY:    vtx_c_xy_ff <= pwdata;
            REG_VERTEX_A_DEPTH: vtx_a_z_ff  <= pwdata[DEPTH_W-1:0];
            REG_VERTEX_B_DEPTH: vtx_b_z_ff  <= pwdata[DEPTH_W-1:0];
            REG_VERTEX_C_DEPTH: vtx_c_z_ff  <= pwdata[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_VERTEX_A_XY:    prdata = vtx_a_xy_ff;
         REG_VERTEX_B_XY:    prdata = vtx_b_xy_ff;
         REG_VERTEX_C_XY:    prdata = vtx_c_xy_ff;
         REG_VERTEX_A_DEPTH: prdata = CSR_DATA_W'(vtx_a_z_ff);
         REG_VERTEX_B_DEPTH: prdata = CSR_DATA_W'(vtx_b_z_ff);
         REG_VERTEX_C_DEPTH: prdata = CSR_DATA_W'(vtx_c_z_ff);
         default:            prdata = '0;
      endcase
   end

   // ---- pipeline advance ----
   assign adv       = ~rsp_valid_ff | rsp_ready;
   assign req_ready = adv;

   tcbd_edge u_edge (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_valid),
      .in_pix    (req_data),
      .vtx_a_xy  (vtx_a_xy_ff),
      .vtx_b_xy  (vtx_b_xy_ff),
      .vtx_c_xy  (vtx_c_xy_ff),
      .out_valid (e_valid),
      .na        (na),
      .nb        (nb),
      .nc        (nc),
      .area      (area)
   );

   // ---- stage 4: signs, magnitudes, depth products ----
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ff.valid <= 1'b0;
      end else if (adv) begin
         s4_ff.valid <= e_valid;
      end
      if (adv) begin
         s4_ff.covered <= (na > 0 && nb > 0 && nc > 0) || (na < 0 && nb < 0 && nc < 0);
         s4_ff.degen   <= area == '0;
         s4_ff.neg_a   <= na[EDGE_W-1] ^ area[EDGE_W-1];
         s4_ff.neg_b   <= nb[EDGE_W-1] ^ area[EDGE_W-1];
         s4_ff.neg_c   <= nc[EDGE_W-1] ^ area[EDGE_W-1];
         s4_ff.neg_z   <= 1'b0;
         neg_d_ff      <= area[EDGE_W-1];
         abs_a_ff      <= na[EDGE_W-1] ? ABS_W'(-na) : ABS_W'(na);
         abs_b_ff      <= nb[EDGE_W-1] ? ABS_W'(-nb) : ABS_W'(nb);
         abs_c_ff      <= nc[EDGE_W-1] ? ABS_W'(-nc) : ABS_W'(nc);
         abs_d_ff      <= area[EDGE_W-1] ? ABS_W'(-area) : ABS_W'(area);
         zp_a_ff       <= ZPROD_W'(na) * ZPROD_W'($signed({1'b0, vtx_a_z_ff}));
         zp_b_ff       <= ZPROD_W'(nb) * ZPROD_W'($signed({1'b0, vtx_b_z_ff}));
         zp_c_ff       <= ZPROD_W'(nc) * ZPROD_W'($signed({1'b0, vtx_c_z_ff}));
      end
   end

   // ---- stage 5: rounded numerators ----
   always_comb begin
      zsum  = ZSUM_W'(zp_a_ff) + ZSUM_W'(zp_b_ff) + ZSUM_W'(zp_c_ff);
      zabs  = zsum[ZSUM_W-1] ? ZSUM_W'(-zsum) : ZSUM_W'(zsum);
      half  = DIV_NUM_W'(abs_d_ff >> 1);
      s5_in = s4_ff;
      s5_in.neg_z = zsum[ZSUM_W-1] ^ neg_d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_ff.valid <= 1'b0;
      end else if (adv) begin
         s5_ff.valid <= s4_ff.valid;
      end
      if (adv) begin
         s5_ff.covered <= s5_in.covered;
         s5_ff.degen   <= s5_in.degen;
         s5_ff.neg_a   <= s5_in.neg_a;
         s5_ff.neg_b   <= s5_in.neg_b;
         s5_ff.neg_c   <= s5_in.neg_c;
         s5_ff.neg_z   <= s5_in.neg_z;
         num_a_ff      <= DIV_NUM_W'({abs_a_ff, WEIGHT_FRAC_BITS'(0)}) + half;
         num_b_ff      <= DIV_NUM_W'({abs_b_ff, WEIGHT_FRAC_BITS'(0)}) + half;
         num_c_ff      <= DIV_NUM_W'({abs_c_ff, WEIGHT_FRAC_BITS'(0)}) + half;
         num_z_ff      <= DIV_NUM_W'(zabs) + half;
         den_ff        <= abs_d_ff;
      end
   end

   // ---- dividers ----
   tcbd_divider #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W), .Q_W(DIV_Q_W)) u_div_a (
      .clock (clock), .en (adv), .num (num_a_ff), .den (den_ff), .quo (q_a), .ovf (o_a)
   );
   tcbd_divider #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W), .Q_W(DIV_Q_W)) u_div_b (
      .clock (clock), .en (adv), .num (num_b_ff), .den (den_ff), .quo (q_b), .ovf (o_b)
   );
   tcbd_divider #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W), .Q_W(DIV_Q_W)) u_div_c (
      .clock (clock), .en (adv), .num (num_c_ff), .den (den_ff), .quo (q_c), .ovf (o_c)
   );
   tcbd_divider #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W), .Q_W(DIV_Q_W)) u_div_z (
      .clock (clock), .en (adv), .num (num_z_ff), .den (den_ff), .quo (q_z), .ovf (o_z)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            side_ff[i] <= '0;
         end
      end else if (adv) begin
         side_ff[0] <= s5_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // ---- saturation and output register ----
   function automatic logic [WEIGHT_W-1:0] sat_w(input logic [DIV_Q_W-1:0] q,
                                                 input logic ov, input logic neg);
      logic [WEIGHT_W-1:0] r;
      begin
         if (!neg) begin
            r = (ov || q[DIV_Q_W-1]) ? {1'b0, {(WEIGHT_W-1){1'b1}}} : WEIGHT_W'(q);
         end else begin
            r = (ov || q > {1'b1, {(DIV_Q_W-1){1'b0}}}) ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                                          : WEIGHT_W'(-q);
         end
         sat_w = r;
      end
   endfunction

   always_comb begin
      rsp_in.inside_res = side_ff[DIV_LAT-1].covered;
      rsp_in.degenerate = side_ff[DIV_LAT-1].degen;
      if (side_ff[DIV_LAT-1].degen) begin
         rsp_in.weight_a = '0;
         rsp_in.weight_b = '0;
         rsp_in.weight_c = '0;
         rsp_in.depth    = '0;
      end else begin
         rsp_in.weight_a = sat_w(q_a, o_a, side_ff[DIV_LAT-1].neg_a);
         rsp_in.weight_b = sat_w(q_b, o_b, side_ff[DIV_LAT-1].neg_b);
         rsp_in.weight_c = sat_w(q_c, o_c, side_ff[DIV_LAT-1].neg_c);
         if (side_ff[DIV_LAT-1].neg_z) begin
            rsp_in.depth = '0;
         end else if (o_z || (|q_z[DIV_Q_W-1:DEPTH_W])) begin
            rsp_in.depth = '1;
         end else begin
            rsp_in.depth = q_z[DEPTH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= side_ff[DIV_LAT-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |-> rsp_data.weight_a == 0
         && rsp_data.weight_b == 0 && rsp_data.weight_c == 0
         && rsp_data.depth == 0 && !rsp_data.inside_res)
      else $error("degenerate result with non-zero fields");
   a_inside_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.inside_res |-> !rsp_data.weight_a[WEIGHT_W-1]
         && !rsp_data.weight_b[WEIGHT_W-1] && !rsp_data.weight_c[WEIGHT_W-1])
      else $error("inside sample with negative weight");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("pipeline advance mismatch");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result transfer changed");
`endif

endmodule
`default_nettype wire
